// ----- rtl/thi_pkg.sv -----
// ----------------------------------------------------------------------------
// thi_pkg
// Types and constants shared by the triangle height interpolator.
// ----------------------------------------------------------------------------
package thi_pkg;

	localparam int COORD_BITS  = 16;
	localparam int FRAC_BITS   = 8;
	localparam int HEIGHT_BITS = COORD_BITS + FRAC_BITS;
	localparam int DIF_BITS    = COORD_BITS + 1;
	localparam int PRD_BITS    = 2 * DIF_BITS;
	localparam int DET_BITS    = PRD_BITS + 1;
	localparam int TOT_BITS    = DET_BITS + COORD_BITS + 3;
	localparam int MAG_BITS    = TOT_BITS + FRAC_BITS;
	localparam int QUO_BITS    = HEIGHT_BITS;

	localparam logic signed [HEIGHT_BITS-1:0] H_ERR = HEIGHT_BITS'(-(2 ** FRAC_BITS));
	localparam logic [HEIGHT_BITS-1:0] H_MAX = {1'b0, {(HEIGHT_BITS-1){1'b1}}};

	typedef enum logic [1:0] {
		ST_INSIDE  = 2'd0,
		ST_VERTEX  = 2'd1,
		ST_OUTSIDE = 2'd2,
		ST_DEGEN   = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] vertex_a_x;
		logic signed [COORD_BITS-1:0] vertex_a_y;
		logic signed [COORD_BITS-1:0] vertex_a_z;
		logic signed [COORD_BITS-1:0] vertex_b_x;
		logic signed [COORD_BITS-1:0] vertex_b_y;
		logic signed [COORD_BITS-1:0] vertex_b_z;
		logic signed [COORD_BITS-1:0] vertex_c_x;
		logic signed [COORD_BITS-1:0] vertex_c_y;
		logic signed [COORD_BITS-1:0] vertex_c_z;
	} in_word_t;

	typedef struct packed {
		logic signed [HEIGHT_BITS-1:0] height;
		status_t                       status;
	} out_word_t;

	// travels alongside the divider
	typedef struct packed {
		logic                          neg;
		status_t                       status;
		logic signed [HEIGHT_BITS-1:0] height;
	} side_t;

endpackage

// ----- rtl/thi_div.sv -----
// ----------------------------------------------------------------------------
// thi_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module thi_div import thi_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                vld,
	input  logic [MAG_BITS-1:0] mag,
	input  logic [DET_BITS-1:0] den,
	input  side_t               side,
	output logic                vld_o,
	output logic [QUO_BITS-1:0] quo,
	output side_t               side_o
);

	logic                v_s   [QUO_BITS];
	logic [DET_BITS-1:0] rem_s [QUO_BITS];
	logic [QUO_BITS-1:0] num_s [QUO_BITS];
	logic [QUO_BITS-1:0] quo_s [QUO_BITS];
	logic [DET_BITS-1:0] den_s [QUO_BITS];
	side_t               side_s[QUO_BITS];

	logic                v_p   [QUO_BITS];
	logic [DET_BITS-1:0] rem_p [QUO_BITS];
	logic [QUO_BITS-1:0] num_p [QUO_BITS];
	logic [QUO_BITS-1:0] quo_p [QUO_BITS];
	logic [DET_BITS-1:0] den_p [QUO_BITS];
	side_t               side_p[QUO_BITS];

	genvar k;
	generate
		for (k = 0; k < QUO_BITS; k++) begin : g_stage
			logic [DET_BITS:0] t;
			logic              ge;

			if (k == 0) begin : g_first
				assign v_p[k]    = vld;
				assign rem_p[k]  = mag[QUO_BITS+DET_BITS-1:QUO_BITS];
				assign num_p[k]  = mag[QUO_BITS-1:0];
				assign quo_p[k]  = '0;
				assign den_p[k]  = den;
				assign side_p[k] = side;
			end else begin : g_next
				assign v_p[k]    = v_s[k-1];
				assign rem_p[k]  = rem_s[k-1];
				assign num_p[k]  = num_s[k-1];
				assign quo_p[k]  = quo_s[k-1];
				assign den_p[k]  = den_s[k-1];
				assign side_p[k] = side_s[k-1];
			end

			assign t  = {rem_p[k], num_p[k][QUO_BITS-1]};
			assign ge = t >= {1'b0, den_p[k]};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (adv) begin
					v_s[k] <= v_p[k];
				end
			end

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[k]  <= ge ? DET_BITS'(t - {1'b0, den_p[k]}) : t[DET_BITS-1:0];
					num_s[k]  <= num_p[k] << 1;
					quo_s[k]  <= {quo_p[k][QUO_BITS-2:0], ge};
					den_s[k]  <= den_p[k];
					side_s[k] <= side_p[k];
				end
			end
		end
	endgenerate

	assign vld_o  = v_s[QUO_BITS-1];
	assign quo    = quo_s[QUO_BITS-1];
	assign side_o = side_s[QUO_BITS-1];

endmodule

// ----- rtl/triangle_height_interpolator.sv -----
// ----------------------------------------------------------------------------
// triangle_height_interpolator
// Height of a triangle's plane under a query point, signed Q8 with status.
// ----------------------------------------------------------------------------
// Pipeline: 6 arithmetic stages, 24 divider stages and 1 output register
// from accepted word to output word.
// Throughput: one word per cycle; the whole pipeline freezes while the output
// word is stalled.
// Reset clears all valid bits; payload registers are not reset.
module triangle_height_interpolator import thi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// s1: differences, vertex hit
	logic                          v_s1;
	logic signed [DIF_BITS-1:0]    dxb_s1, dyb_s1, dzb_s1, dxc_s1, dyc_s1, dzc_s1, ex_s1, ey_s1;
	logic signed [COORD_BITS-1:0]  za_s1;
	logic                          hit_s1;
	logic signed [HEIGHT_BITS-1:0] vz_s1;

	logic                          hit_a, hit_b, hit_c;
	logic signed [COORD_BITS-1:0]  hz;
	assign hit_a = in_word.vertex_a_x == in_word.point_x && in_word.vertex_a_y == in_word.point_y;
	assign hit_b = in_word.vertex_b_x == in_word.point_x && in_word.vertex_b_y == in_word.point_y;
	assign hit_c = in_word.vertex_c_x == in_word.point_x && in_word.vertex_c_y == in_word.point_y;
	assign hz    = hit_a ? in_word.vertex_a_z : (hit_b ? in_word.vertex_b_z : in_word.vertex_c_z);

	// s2: cross products
	logic                          v_s2;
	logic signed [PRD_BITS-1:0]    p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [DIF_BITS-1:0]    dzb_s2, dzc_s2;
	logic signed [COORD_BITS-1:0]  za_s2;
	logic                          hit_s2;
	logic signed [HEIGHT_BITS-1:0] vz_s2;

	// s3: determinant and numerators
	logic                          v_s3;
	logic signed [DET_BITS-1:0]    d_s3, nu_s3, nv_s3;
	logic signed [DIF_BITS-1:0]    dzb_s3, dzc_s3;
	logic signed [COORD_BITS-1:0]  za_s3;
	logic                          hit_s3;
	logic signed [HEIGHT_BITS-1:0] vz_s3;

	// s4: sign normalized
	logic                          v_s4;
	logic signed [DET_BITS-1:0]    d_s4, nu_s4, nv_s4;
	logic                          degen_s4;
	logic signed [DIF_BITS-1:0]    dzb_s4, dzc_s4;
	logic signed [COORD_BITS-1:0]  za_s4;
	logic                          hit_s4;
	logic signed [HEIGHT_BITS-1:0] vz_s4;

	// s5: containment, weighted heights
	logic                          v_s5;
	logic signed [TOT_BITS-1:0]    pa_s5, pb_s5, pc_s5;
	logic [DET_BITS-1:0]           d_s5;
	status_t                       st_s5;
	logic signed [HEIGHT_BITS-1:0] alt_s5;

	// s6: magnitude for the divider
	logic                          v_s6;
	logic [MAG_BITS-1:0]           mag_s6;
	logic [DET_BITS-1:0]           d_s6;
	side_t                         side_s6;

	logic signed [DET_BITS:0]      uv_sum;
	logic                          outside;
	logic signed [TOT_BITS-1:0]    tot;
	logic [TOT_BITS-1:0]           tot_abs;

	assign uv_sum  = (DET_BITS+1)'(nu_s4) + (DET_BITS+1)'(nv_s4);
	assign outside = nu_s4 < 0 || nv_s4 < 0 || nu_s4 > d_s4 || nv_s4 > d_s4
		|| uv_sum > (DET_BITS+1)'(d_s4);
	assign tot     = pa_s5 + pb_s5 + pc_s5;
	assign tot_abs = tot[TOT_BITS-1] ? -tot : tot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dxb_s1 <= DIF_BITS'(in_word.vertex_b_x) - DIF_BITS'(in_word.vertex_a_x);
			dyb_s1 <= DIF_BITS'(in_word.vertex_b_y) - DIF_BITS'(in_word.vertex_a_y);
			dzb_s1 <= DIF_BITS'(in_word.vertex_b_z) - DIF_BITS'(in_word.vertex_a_z);
			dxc_s1 <= DIF_BITS'(in_word.vertex_c_x) - DIF_BITS'(in_word.vertex_a_x);
			dyc_s1 <= DIF_BITS'(in_word.vertex_c_y) - DIF_BITS'(in_word.vertex_a_y);
			dzc_s1 <= DIF_BITS'(in_word.vertex_c_z) - DIF_BITS'(in_word.vertex_a_z);
			ex_s1  <= DIF_BITS'(in_word.point_x) - DIF_BITS'(in_word.vertex_a_x);
			ey_s1  <= DIF_BITS'(in_word.point_y) - DIF_BITS'(in_word.vertex_a_y);
			za_s1  <= in_word.vertex_a_z;
			hit_s1 <= hit_a || hit_b || hit_c;
			vz_s1  <= HEIGHT_BITS'(hz) <<< FRAC_BITS;

			p0_s2  <= PRD_BITS'(dxb_s1) * PRD_BITS'(dyc_s1);
			p1_s2  <= PRD_BITS'(dxc_s1) * PRD_BITS'(dyb_s1);
			p2_s2  <= PRD_BITS'(ex_s1) * PRD_BITS'(dyc_s1);
			p3_s2  <= PRD_BITS'(ey_s1) * PRD_BITS'(dxc_s1);
			p4_s2  <= PRD_BITS'(dxb_s1) * PRD_BITS'(ey_s1);
			p5_s2  <= PRD_BITS'(dyb_s1) * PRD_BITS'(ex_s1);
			dzb_s2 <= dzb_s1;
			dzc_s2 <= dzc_s1;
			za_s2  <= za_s1;
			hit_s2 <= hit_s1;
			vz_s2  <= vz_s1;

			d_s3   <= DET_BITS'(p0_s2) - DET_BITS'(p1_s2);
			nu_s3  <= DET_BITS'(p2_s2) - DET_BITS'(p3_s2);
			nv_s3  <= DET_BITS'(p4_s2) - DET_BITS'(p5_s2);
			dzb_s3 <= dzb_s2;
			dzc_s3 <= dzc_s2;
			za_s3  <= za_s2;
			hit_s3 <= hit_s2;
			vz_s3  <= vz_s2;

			d_s4     <= d_s3[DET_BITS-1] ? -d_s3 : d_s3;
			nu_s4    <= d_s3[DET_BITS-1] ? -nu_s3 : nu_s3;
			nv_s4    <= d_s3[DET_BITS-1] ? -nv_s3 : nv_s3;
			degen_s4 <= d_s3 == '0;
			dzb_s4   <= dzb_s3;
			dzc_s4   <= dzc_s3;
			za_s4    <= za_s3;
			hit_s4   <= hit_s3;
			vz_s4    <= vz_s3;

			pa_s5  <= TOT_BITS'(za_s4) * TOT_BITS'(d_s4);
			pb_s5  <= TOT_BITS'(nu_s4) * TOT_BITS'(dzb_s4);
			pc_s5  <= TOT_BITS'(nv_s4) * TOT_BITS'(dzc_s4);
			d_s5   <= d_s4;
			alt_s5 <= hit_s4 ? vz_s4 : H_ERR;
			if (hit_s4) begin
				st_s5 <= ST_VERTEX;
			end else if (degen_s4) begin
				st_s5 <= ST_DEGEN;
			end else if (outside) begin
				st_s5 <= ST_OUTSIDE;
			end else begin
				st_s5 <= ST_INSIDE;
			end

			mag_s6         <= MAG_BITS'(tot_abs) << FRAC_BITS;
			d_s6           <= (st_s5 == ST_INSIDE) ? d_s5 : DET_BITS'(1);
			side_s6.neg    <= tot[TOT_BITS-1];
			side_s6.status <= st_s5;
			side_s6.height <= alt_s5;
		end
	end

	logic                div_v;
	logic [QUO_BITS-1:0] div_q;
	side_t               div_side;

	thi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld    (v_s6),
		.mag    ((side_s6.status == ST_INSIDE) ? mag_s6 : '0),
		.den    (d_s6),
		.side   (side_s6),
		.vld_o  (div_v),
		.quo    (div_q),
		.side_o (div_side)
	);

	logic [HEIGHT_BITS-1:0] h_in;
	assign h_in = div_side.neg ? HEIGHT_BITS'(0 - div_q)
		: (div_q[QUO_BITS-1] ? H_MAX : div_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= div_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_word.status <= div_side.status;
			out_word.height <= (div_side.status == ST_INSIDE) ? h_in : div_side.height;
		end
	end

	a_err_height: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.status == ST_OUTSIDE || out_word.status == ST_DEGEN)
		|-> out_word.height == H_ERR)
		else $error("error status without error height");

	a_stall_tie: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall not tied to output stall");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(v_s6) && $stable(div_v))
		else $error("pipeline moved while stalled");

endmodule
